/* hdl/nmea_pkg.sv */
// ----------------------------------------------------------------------------
// nmea_pkg
// Shared types and constants of the sentence checksum framer: character
// classes, result and status codes, register map and queue entry layouts.
// ----------------------------------------------------------------------------
package nmea_pkg;

  // Default bound on counted body characters
  localparam int unsigned MaxBodyDefault = 128;

  // Queue depths between the parts (powers of two)
  localparam int unsigned CharQDepth = 4;
  localparam int unsigned ResQDepth  = 2;

  // Register port
  localparam int unsigned AddrWidth = 4;
  localparam int unsigned DataWidth = 32;

  // Framing characters
  localparam logic [7:0] ChDollar  = 8'h24;
  localparam logic [7:0] ChStar    = 8'h2A;
  localparam logic [7:0] ChNewline = 8'h0A;

  // Talker register reset values ("G", "P")
  localparam logic [7:0] TalkerFirstReset  = 8'h47;
  localparam logic [7:0] TalkerSecondReset = 8'h50;

  // Sentence type letters, first letter in the high byte
  localparam logic [23:0] LettersGsv = 24'h475356;
  localparam logic [23:0] LettersGga = 24'h474741;
  localparam logic [23:0] LettersRmc = 24'h524D43;
  localparam logic [23:0] LettersGll = 24'h474C4C;

  typedef enum logic [1:0] {
    RegPaused       = 2'd0,
    RegTalkerFirst  = 2'd1,
    RegTalkerSecond = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StNoTalker = 3'd1,
    StNoStar   = 3'd2,
    StMismatch = 3'd3,
    StOverflow = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    TypeOther = 3'd0,
    TypeGsv   = 3'd1,
    TypeGga   = 3'd2,
    TypeRmc   = 3'd3,
    TypeGll   = 3'd4
  } stype_e;

  typedef enum logic [2:0] {
    ClsDollar  = 3'd0,
    ClsNewline = 3'd1,
    ClsStar    = 3'd2,
    ClsHex     = 3'd3,
    ClsOther   = 3'd4
  } cls_e;

  // Classified character, front to back
  typedef struct packed {
    cls_e       cls;
    logic [7:0] ch;
    logic [3:0] hex;
  } char_item_t;

  // One finished sentence report
  typedef struct packed {
    status_e    status;
    stype_e     stype;
    logic [7:0] computed_sum;
    logic [7:0] received_sum;
    logic [7:0] body_length;
  } result_t;

  // Configuration register contents
  typedef struct packed {
    logic       paused;
    logic [7:0] talker_first;
    logic [7:0] talker_second;
  } cfg_t;

endpackage

/* hdl/nmea_fifo.sv */
// ----------------------------------------------------------------------------
// nmea_fifo
// Small flip-flop queue with first-word fall-through output.
// ----------------------------------------------------------------------------
module nmea_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entry
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* hdl/nmea_cfg.sv */
// ----------------------------------------------------------------------------
// nmea_cfg
// Register file behind the APB-style port: pause bit and talker characters.
// ----------------------------------------------------------------------------
module nmea_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [nmea_pkg::AddrWidth-1:0] paddr,
  input  logic [nmea_pkg::DataWidth-1:0] pwdata,
  output logic [nmea_pkg::DataWidth-1:0] prdata,
  output logic                           pready,
  output nmea_pkg::cfg_t                 cfg_o
);

  import nmea_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg_o  = cfg_q;

  // Decode writes
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        RegPaused:       cfg_d.paused        = pwdata[0];
        RegTalkerFirst:  cfg_d.talker_first  = pwdata[7:0];
        RegTalkerSecond: cfg_d.talker_second = pwdata[7:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  // Decode reads
  always_comb begin
    unique case (idx)
      RegPaused:       prdata = {{(DataWidth - 1){1'b0}}, cfg_q.paused};
      RegTalkerFirst:  prdata = {{(DataWidth - 8){1'b0}}, cfg_q.talker_first};
      RegTalkerSecond: prdata = {{(DataWidth - 8){1'b0}}, cfg_q.talker_second};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.paused        <= 1'b0;
      cfg_q.talker_first  <= TalkerFirstReset;
      cfg_q.talker_second <= TalkerSecondReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* hdl/nmea_front.sv */
// ----------------------------------------------------------------------------
// nmea_front
// Accepts characters, drops them while paused, and classifies each one as
// dollar, newline, star, hex digit or other before queueing it.
// ----------------------------------------------------------------------------
module nmea_front (
  input  logic                 push_i,
  input  logic [7:0]           char_in_i,
  input  logic                 q_full_i,
  input  nmea_pkg::cfg_t       cfg_i,
  output logic                 q_push_o,
  output nmea_pkg::char_item_t item_o
);

  import nmea_pkg::*;

  logic is_dec, is_upper, is_lower;

  assign is_dec   = (char_in_i >= 8'h30) && (char_in_i <= 8'h39);
  assign is_upper = (char_in_i >= 8'h41) && (char_in_i <= 8'h46);
  assign is_lower = (char_in_i >= 8'h61) && (char_in_i <= 8'h66);

  // Queue every accepted request unless paused
  assign q_push_o = push_i && !q_full_i && !cfg_i.paused;

  // Classify the character and take its hex value
  always_comb begin
    item_o.ch  = char_in_i;
    item_o.hex = is_dec ? char_in_i[3:0] : char_in_i[3:0] + 4'd9;
    if (char_in_i == ChDollar) begin
      item_o.cls = ClsDollar;
    end else if (char_in_i == ChNewline) begin
      item_o.cls = ClsNewline;
    end else if (char_in_i == ChStar) begin
      item_o.cls = ClsStar;
    end else if (is_dec || is_upper || is_lower) begin
      item_o.cls = ClsHex;
    end else begin
      item_o.cls = ClsOther;
    end
  end

endmodule

/* hdl/nmea_back.sv */
// ----------------------------------------------------------------------------
// nmea_back
// Sentence tracker: runs the XOR and body count, checks the talker, collects
// type letters and checksum digits, and builds a report at each newline.
// ----------------------------------------------------------------------------
module nmea_back #(
  parameter int unsigned MAX_BODY = nmea_pkg::MaxBodyDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  nmea_pkg::cfg_t       cfg_i,
  input  nmea_pkg::char_item_t item_i,
  input  logic                 item_empty_i,
  output logic                 item_pop_o,
  input  logic                 res_full_i,
  output logic                 res_push_o,
  output nmea_pkg::result_t    res_o
);

  import nmea_pkg::*;

  localparam logic [7:0] MaxBody = 8'(MAX_BODY);

  logic        open_q, open_d;
  logic        star_q, star_d;
  logic [7:0]  xor_q, xor_d;
  logic [7:0]  rx_q, rx_d;
  logic [1:0]  hcnt_q, hcnt_d;
  logic        ended_q, ended_d;
  logic [7:0]  cnt_q, cnt_d;
  logic        talk_q, talk_d;
  logic [23:0] letters_q, letters_d;
  logic        ovf_q, ovf_d;

  // Take the next character whenever the report queue has room
  assign item_pop_o = !item_empty_i && !res_full_i;
  assign res_push_o = item_pop_o && (item_i.cls == ClsNewline);

  // Update sentence state
  always_comb begin
    open_d    = open_q;
    star_d    = star_q;
    xor_d     = xor_q;
    rx_d      = rx_q;
    hcnt_d    = hcnt_q;
    ended_d   = ended_q;
    cnt_d     = cnt_q;
    talk_d    = talk_q;
    letters_d = letters_q;
    ovf_d     = ovf_q;
    if (item_pop_o) begin
      unique case (item_i.cls)
        ClsDollar: begin
          open_d    = 1'b1;
          star_d    = 1'b0;
          xor_d     = '0;
          rx_d      = '0;
          hcnt_d    = '0;
          ended_d   = 1'b0;
          cnt_d     = '0;
          talk_d    = 1'b0;
          letters_d = '0;
          ovf_d     = 1'b0;
        end
        ClsNewline: begin
          open_d = 1'b0;
        end
        default: begin
          if (open_q) begin
            if (star_q) begin
              // Checksum field: a non-hex character ends it
              if (item_i.cls != ClsHex) begin
                ended_d = 1'b1;
              end else if (!ended_q) begin
                if (hcnt_q == 2'd2) begin
                  ovf_d = 1'b1;
                end else begin
                  rx_d   = {rx_q[3:0], item_i.hex};
                  hcnt_d = hcnt_q + 1'b1;
                end
              end
            end else if (item_i.cls == ClsStar) begin
              star_d = 1'b1;
            end else begin
              // Body character
              xor_d = xor_q ^ item_i.ch;
              if (cnt_q == 8'd0) begin
                talk_d = (item_i.ch == cfg_i.talker_first);
              end else if (cnt_q == 8'd1) begin
                talk_d = talk_q && (item_i.ch == cfg_i.talker_second);
              end else if (cnt_q <= 8'd4) begin
                letters_d = {letters_q[15:0], item_i.ch};
              end
              if (cnt_q < MaxBody) begin
                cnt_d = cnt_q + 1'b1;
              end else begin
                ovf_d = 1'b1;
              end
            end
          end
        end
      endcase
    end
  end

  // Build the report from the state before the newline
  always_comb begin
    res_o.computed_sum = xor_q;
    res_o.received_sum = rx_q;
    res_o.body_length  = cnt_q;
    res_o.stype        = TypeOther;
    if (cnt_q >= 8'd5) begin
      if (letters_q == LettersGsv) begin
        res_o.stype = TypeGsv;
      end else if (letters_q == LettersGga) begin
        res_o.stype = TypeGga;
      end else if (letters_q == LettersRmc) begin
        res_o.stype = TypeRmc;
      end else if (letters_q == LettersGll) begin
        res_o.stype = TypeGll;
      end
    end
    if (!talk_q || cnt_q < 8'd2) begin
      res_o.status = StNoTalker;
    end else if (ovf_q) begin
      res_o.status = StOverflow;
    end else if (!star_q) begin
      res_o.status = StNoStar;
    end else if (rx_q != xor_q) begin
      res_o.status = StMismatch;
    end else begin
      res_o.status = StOk;
    end
    // Newline with no open sentence: bare status
    if (!open_q) begin
      res_o.status       = StNoTalker;
      res_o.stype        = TypeOther;
      res_o.computed_sum = '0;
      res_o.received_sum = '0;
      res_o.body_length  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q    <= 1'b0;
      star_q    <= 1'b0;
      xor_q     <= '0;
      rx_q      <= '0;
      hcnt_q    <= '0;
      ended_q   <= 1'b0;
      cnt_q     <= '0;
      talk_q    <= 1'b0;
      letters_q <= '0;
      ovf_q     <= 1'b0;
    end else begin
      open_q    <= open_d;
      star_q    <= star_d;
      xor_q     <= xor_d;
      rx_q      <= rx_d;
      hcnt_q    <= hcnt_d;
      ended_q   <= ended_d;
      cnt_q     <= cnt_d;
      talk_q    <= talk_d;
      letters_q <= letters_d;
      ovf_q     <= ovf_d;
    end
  end

endmodule

/* hdl/nmea_sentence_checksum_framer_unit.sv */
// ----------------------------------------------------------------------------
// nmea_sentence_checksum_framer_unit
// Frames NMEA 0183 sentences from a character stream and checks their XOR
// checksum, talker and type, giving one report per line.
// ----------------------------------------------------------------------------
// Usage:
//   Characters enter on a queue-style port: a request is taken at a clock
//   edge with push high and full low. Reports leave on a queue-style port:
//   the oldest report sits on the result ports while empty is low and is
//   taken at an edge with pop high.
//   Every newline taken while not paused gives exactly one report; other
//   characters give none. A newline passes the character queue and the
//   tracker, and its report is registered in the report queue.
//   Throughput: one character per clock while the report queue has room.
//   The classifier feeds a 4-entry character queue; the tracker feeds a
//   2-entry report queue. When the receiver stalls, the report queue fills,
//   the tracker halts, and full rises once the character queue is full.
//   Reset empties both queues, closes any sentence and loads the registers
//   with their defaults (not paused, talker "GP").
//   Registers (paddr): 0x0 paused, 0x4 talker first, 0x8 talker second.
//   While paused, characters are taken and discarded.
// ----------------------------------------------------------------------------
module nmea_sentence_checksum_framer_unit #(
  parameter int unsigned MAX_BODY = nmea_pkg::MaxBodyDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // character input
  input  logic                           push,
  output logic                           full,
  input  logic [7:0]                     char_in_i,
  // report output
  output logic                           empty,
  input  logic                           pop,
  output logic [2:0]                     status_o,
  output logic [2:0]                     sentence_type_o,
  output logic [7:0]                     computed_sum_o,
  output logic [7:0]                     received_sum_o,
  output logic [7:0]                     body_length_o,
  // register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [nmea_pkg::AddrWidth-1:0] paddr,
  input  logic [nmea_pkg::DataWidth-1:0] pwdata,
  output logic [nmea_pkg::DataWidth-1:0] prdata,
  output logic                           pready
);

  import nmea_pkg::*;

  localparam int unsigned ItemW = $bits(char_item_t);
  localparam int unsigned ResW  = $bits(result_t);

  cfg_t             cfg;
  char_item_t       front_item, back_item;
  logic [ItemW-1:0] cq_rdata;
  logic             cq_push, cq_pop, cq_empty;
  result_t          back_res, out_res;
  logic [ResW-1:0]  rq_rdata;
  logic             rq_push, rq_full;

  nmea_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .cfg_o (cfg)
  );

  nmea_front u_front (
    .push_i    (push),
    .char_in_i,
    .q_full_i  (full),
    .cfg_i     (cfg),
    .q_push_o  (cq_push),
    .item_o    (front_item)
  );

  // Classified characters between front and back
  nmea_fifo #(
    .WIDTH (ItemW),
    .DEPTH (CharQDepth)
  ) u_char_q (
    .clk_i,
    .rst_ni,
    .push_i  (cq_push),
    .data_i  (front_item),
    .full_o  (full),
    .pop_i   (cq_pop),
    .data_o  (cq_rdata),
    .empty_o (cq_empty)
  );

  assign back_item = char_item_t'(cq_rdata);

  nmea_back #(
    .MAX_BODY (MAX_BODY)
  ) u_back (
    .clk_i,
    .rst_ni,
    .cfg_i        (cfg),
    .item_i       (back_item),
    .item_empty_i (cq_empty),
    .item_pop_o   (cq_pop),
    .res_full_i   (rq_full),
    .res_push_o   (rq_push),
    .res_o        (back_res)
  );

  // Finished reports toward the receiver
  nmea_fifo #(
    .WIDTH (ResW),
    .DEPTH (ResQDepth)
  ) u_res_q (
    .clk_i,
    .rst_ni,
    .push_i  (rq_push),
    .data_i  (back_res),
    .full_o  (rq_full),
    .pop_i   (pop),
    .data_o  (rq_rdata),
    .empty_o (empty)
  );

  assign out_res         = result_t'(rq_rdata);
  assign status_o        = out_res.status;
  assign sentence_type_o = out_res.stype;
  assign computed_sum_o  = out_res.computed_sum;
  assign received_sum_o  = out_res.received_sum;
  assign body_length_o   = out_res.body_length;

endmodule

/* hdl/nmea_chk.sv */
// ----------------------------------------------------------------------------
// nmea_chk
// Port-level checks of the framer: report consistency and output hold.
// ----------------------------------------------------------------------------
module nmea_chk #(
  parameter int unsigned MAX_BODY = nmea_pkg::MaxBodyDefault
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [2:0] status_o,
  input logic [2:0] sentence_type_o,
  input logic [7:0] computed_sum_o,
  input logic [7:0] received_sum_o,
  input logic [7:0] body_length_o
);

  import nmea_pkg::*;

  localparam logic [7:0] MaxBody = 8'(MAX_BODY);

  // A stalled report holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(status_o) && $stable(body_length_o)
                          && $stable(computed_sum_o) && $stable(received_sum_o)))
    else $error("stalled report changed");

  // A good sentence has matching sums and a full talker
  a_ok_sums: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == StOk) |->
      (computed_sum_o == received_sum_o && body_length_o >= 8'd2))
    else $error("ok report with bad sums or short body");

  // A known type needs at least five body characters
  a_type_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && sentence_type_o != TypeOther) |-> (body_length_o >= 8'd5))
    else $error("type reported for short body");

  // Body count saturates at the bound
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (body_length_o <= MaxBody))
    else $error("body length above bound");

  // A talker report at the saturated length has overflow, no-star, mismatch or ok status
  a_ovf_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && body_length_o == MaxBody && status_o != StNoTalker) |->
      (status_o == StOverflow || status_o == StNoStar || status_o == StMismatch
       || status_o == StOk))
    else $error("bad status at saturated length");

endmodule

bind nmea_sentence_checksum_framer_unit nmea_chk #(
  .MAX_BODY (MAX_BODY)
) u_nmea_chk (
  .clk_i,
  .rst_ni,
  .empty,
  .pop,
  .status_o,
  .sentence_type_o,
  .computed_sum_o,
  .received_sum_o,
  .body_length_o
);
